// ----- hdl/gftq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gftq_pkg
// Shared types and constants of the grouped FIFO team queue.
// ----------------------------------------------------------------------------
package gftq_pkg;

    localparam int TEAMS     = 1024;
    localparam int TEAM_BITS = 10;
    localparam int ELEM_BITS = 20;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    localparam logic [1:0] ST_ENQ   = 2'd0;
    localparam logic [1:0] ST_DEQ   = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [TEAM_BITS-1:0] team;
        logic [ELEM_BITS-1:0] value;
    } t_node_data;

    typedef struct packed {
        logic rd;
        logic wr;
    } t_team_cmd;

endpackage

// ----- hdl/grouped_fifo_team_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grouped_fifo_team_queue
// Steps: errors finish in the accepting idle state; an append at the global
// tail passes through E1, a join behind a teammate through E1, E2 and E3, and a
// dequeue through D1 and D2; the result goes to a pending register and then
// sits in the output register. A new item is taken only in the idle state,
// after the read-modify-write sequence on the link and team memories is done.
// Reset: synchronous; the team store then clears every entry with s_tready low.
// ----------------------------------------------------------------------------
module grouped_fifo_team_queue
    import gftq_pkg::*;
#(
    parameter int NODES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // element[19:0], team_id[29:20], zero pad
    input  logic [0:0]  i_s_tuser,   // cmd[0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // out_element[19:0], zero pad
    output logic [1:0]  o_m_tuser    // status[1:0]
);

    localparam int NB = $clog2(NODES);
    localparam int TW = $clog2(NODES + 1);
    localparam logic [TW-1:0] LP_ALL_FREE = TW'(NODES);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_E1   = 3'd1;
    localparam logic [2:0] S_E2   = 3'd2;
    localparam logic [2:0] S_E3   = 3'd3;
    localparam logic [2:0] S_D1   = 3'd4;
    localparam logic [2:0] S_D2   = 3'd5;

    // memories
    t_node_data         r_nd_mem [NODES];
    logic [NB-1:0]      r_lk_mem [NODES];
    logic [NB-1:0]      r_fs_mem [NODES];
    t_node_data         r_nd_rdata;
    logic [NB-1:0]      r_lk_rdata;
    logic [NB-1:0]      r_fs_rdata;

    logic               nd_re, nd_we, lk_re, lk_we, fs_re, fs_we;
    logic [NB-1:0]      nd_addr, lk_raddr, lk_waddr, lk_wdata, fs_addr, fs_wdata;
    t_node_data         nd_wdata;

    t_team_cmd          tm_cmd;
    logic [TEAM_BITS-1:0] tm_addr;
    logic [NB:0]        tm_wdata;
    logic [NB:0]        tm_rdata;
    logic               tm_busy;

    // control and payload registers
    logic [2:0]         r_state, n_state;
    logic [TW-1:0]      r_top, n_top;
    logic [TW-1:0]      r_low, n_low;
    logic [NB-1:0]      r_head, n_head;
    logic [NB-1:0]      r_tail, n_tail;
    logic [NB-1:0]      r_node, n_node;
    logic [NB-1:0]      r_mate, n_mate;
    logic [ELEM_BITS-1:0] r_elem, n_elem;
    logic [TEAM_BITS-1:0] r_team, n_team;
    logic               r_was_empty, n_was_empty;
    logic               r_pend_v, n_pend_v;
    logic [1:0]         r_pend_st, n_pend_st;
    logic [ELEM_BITS-1:0] r_pend_el, n_pend_el;
    logic               r_ov, n_ov;
    logic [1:0]         r_ost, n_ost;
    logic [ELEM_BITS-1:0] r_oel, n_oel;

    logic               accept, out_free, move, fin;
    logic [1:0]         fin_st;
    logic [ELEM_BITS-1:0] fin_el;
    logic [TW-1:0]      pop_idx;
    logic [NB-1:0]      new_node;

    assign out_free   = !r_ov || i_m_tready;
    assign move       = r_pend_v && out_free;
    assign o_s_tready = (r_state == S_IDLE) && !tm_busy && (!r_pend_v || out_free);
    assign accept     = i_s_tvalid && o_s_tready;
    assign pop_idx    = r_top - TW'(1);
    assign new_node   = (pop_idx < r_low) ? pop_idx[NB-1:0] : r_fs_rdata;

    always_comb begin
        n_state     = r_state;
        n_top       = r_top;
        n_low       = r_low;
        n_head      = r_head;
        n_tail      = r_tail;
        n_node      = r_node;
        n_mate      = r_mate;
        n_elem      = r_elem;
        n_team      = r_team;
        n_was_empty = r_was_empty;
        fin         = 1'b0;
        fin_st      = ST_ENQ;
        fin_el      = '0;
        nd_re       = 1'b0;
        nd_we       = 1'b0;
        nd_addr     = r_head;
        nd_wdata    = '{team: r_team, value: r_elem};
        lk_re       = 1'b0;
        lk_raddr    = r_head;
        lk_we       = 1'b0;
        lk_waddr    = r_tail;
        lk_wdata    = r_node;
        fs_re       = 1'b0;
        fs_we       = 1'b0;
        fs_addr     = pop_idx[NB-1:0];
        fs_wdata    = r_node;
        tm_cmd      = '{rd: 1'b0, wr: 1'b0};
        tm_addr     = r_team;
        tm_wdata    = {1'b1, new_node};

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_s_tuser[0] == CMD_ENQ) begin
                        if (r_top == '0) begin
                            fin    = 1'b1;
                            fin_st = ST_FULL;
                        end else begin
                            n_elem      = i_s_tdata[ELEM_BITS-1:0];
                            n_team      = i_s_tdata[ELEM_BITS +: TEAM_BITS];
                            n_was_empty = (r_top == LP_ALL_FREE);
                            tm_cmd.rd   = 1'b1;
                            tm_addr     = i_s_tdata[ELEM_BITS +: TEAM_BITS];
                            fs_re       = 1'b1;
                            n_state     = S_E1;
                        end
                    end else begin
                        if (r_top == LP_ALL_FREE) begin
                            fin    = 1'b1;
                            fin_st = ST_EMPTY;
                        end else begin
                            nd_re    = 1'b1;
                            lk_re    = 1'b1;
                            n_node   = r_head;
                            n_state  = S_D1;
                        end
                    end
                end
            end
            S_E1: begin
                n_node    = new_node;
                nd_we     = 1'b1;
                nd_addr   = new_node;
                tm_cmd.wr = 1'b1;
                n_top     = pop_idx;
                if (pop_idx < r_low) begin
                    n_low = pop_idx;
                end
                if (r_was_empty) begin
                    n_head = new_node;
                    n_tail = new_node;
                    fin    = 1'b1;
                end else if (tm_rdata[NB]) begin
                    n_mate   = tm_rdata[NB-1:0];
                    lk_re    = 1'b1;
                    lk_raddr = tm_rdata[NB-1:0];
                    n_state  = S_E2;
                end else begin
                    lk_we    = 1'b1;
                    lk_waddr = r_tail;
                    lk_wdata = new_node;
                    n_tail   = new_node;
                    fin      = 1'b1;
                end
            end
            S_E2: begin
                lk_we    = 1'b1;
                lk_waddr = r_node;
                lk_wdata = r_lk_rdata;
                if (r_tail == r_mate) begin
                    n_tail = r_node;
                end
                n_state = S_E3;
            end
            S_E3: begin
                lk_we    = 1'b1;
                lk_waddr = r_mate;
                lk_wdata = r_node;
                fin      = 1'b1;
            end
            S_D1: begin
                n_team    = r_nd_rdata.team;
                n_elem    = r_nd_rdata.value;
                tm_cmd.rd = 1'b1;
                tm_addr   = r_nd_rdata.team;
                fs_we     = 1'b1;
                fs_addr   = r_top[NB-1:0];
                fs_wdata  = r_node;
                n_top     = r_top + TW'(1);
                if (r_top + TW'(1) == LP_ALL_FREE) begin
                    n_head = '0;
                    n_tail = '0;
                end else begin
                    n_head = r_lk_rdata;
                end
                n_state = S_D2;
            end
            S_D2: begin
                tm_wdata = {1'b0, tm_rdata[NB-1:0]};
                if (tm_rdata[NB] && tm_rdata[NB-1:0] == r_node) begin
                    tm_cmd.wr = 1'b1;
                end
                fin    = 1'b1;
                fin_st = ST_DEQ;
                fin_el = r_elem;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            n_state = S_IDLE;
        end
    end

    always_comb begin
        n_pend_v  = r_pend_v;
        n_pend_st = r_pend_st;
        n_pend_el = r_pend_el;
        n_ov      = r_ov;
        n_ost     = r_ost;
        n_oel     = r_oel;
        if (move) begin
            n_ov     = 1'b1;
            n_ost    = r_pend_st;
            n_oel    = r_pend_el;
            n_pend_v = 1'b0;
        end else if (i_m_tready) begin
            n_ov = 1'b0;
        end
        if (fin) begin
            n_pend_v  = 1'b1;
            n_pend_st = fin_st;
            n_pend_el = fin_el;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_top    <= LP_ALL_FREE;
            r_low    <= LP_ALL_FREE;
            r_head   <= '0;
            r_tail   <= '0;
            r_pend_v <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_top    <= n_top;
            r_low    <= n_low;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_pend_v <= n_pend_v;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node      <= n_node;
        r_mate      <= n_mate;
        r_elem      <= n_elem;
        r_team      <= n_team;
        r_was_empty <= n_was_empty;
        r_pend_st   <= n_pend_st;
        r_pend_el   <= n_pend_el;
        r_ost       <= n_ost;
        r_oel       <= n_oel;
    end

    always_ff @(posedge i_clk) begin
        if (nd_we) begin
            r_nd_mem[nd_addr] <= nd_wdata;
        end
        if (nd_re) begin
            r_nd_rdata <= r_nd_mem[nd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (lk_we) begin
            r_lk_mem[lk_waddr] <= lk_wdata;
        end
        if (lk_re) begin
            r_lk_rdata <= r_lk_mem[lk_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (fs_we) begin
            r_fs_mem[fs_addr] <= fs_wdata;
        end
        if (fs_re) begin
            r_fs_rdata <= r_fs_mem[fs_addr];
        end
    end

    gftq_team_mem #(
        .TAIL_BITS (NB)
    ) u_team_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (tm_cmd),
        .i_addr  (tm_addr),
        .i_wdata (tm_wdata),
        .o_rdata (tm_rdata),
        .o_busy  (tm_busy)
    );

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {(24 - ELEM_BITS)'(0), r_oel};
    assign o_m_tuser  = r_ost;

    a_top_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= LP_ALL_FREE) else $error("free count out of range");
    a_low_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_low <= r_top) else $error("low mark above free count");
    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_top == LP_ALL_FREE) |-> (r_head == '0 && r_tail == '0))
        else $error("pointers not cleared on empty queue");
    a_zero_elem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_ost != ST_DEQ) |-> r_oel == '0)
        else $error("element nonzero on non-dequeue result");

endmodule

// ----- hdl/gftq_team_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gftq_team_mem
// Per-team store of {present, tail node}, with a read and a write enable on one
// shared address and registered read data. Sweeps every entry to cleared after reset.
// ----------------------------------------------------------------------------
module gftq_team_mem
    import gftq_pkg::*;
#(
    parameter int TAIL_BITS = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_team_cmd              i_cmd,
    input  logic [TEAM_BITS-1:0]   i_addr,
    input  logic [TAIL_BITS:0]     i_wdata,
    output logic [TAIL_BITS:0]     o_rdata,
    output logic                   o_busy
);

    logic [TAIL_BITS:0]   r_mem [TEAMS];
    logic [TAIL_BITS:0]   r_rdata;
    logic [TEAM_BITS:0]   r_clr_cnt;
    logic [TEAM_BITS:0]   n_clr_cnt;
    logic                 r_busy;
    logic                 n_busy;

    always_comb begin
        n_clr_cnt = r_clr_cnt;
        n_busy    = r_busy;
        if (r_busy) begin
            n_clr_cnt = r_clr_cnt + (TEAM_BITS+1)'(1);
            if (r_clr_cnt == (TEAM_BITS+1)'(TEAMS - 1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
            r_busy    <= 1'b1;
        end else begin
            r_clr_cnt <= n_clr_cnt;
            r_busy    <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_cnt[TEAM_BITS-1:0]] <= '0;
        end else if (i_cmd.wr) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_busy;

    a_no_wr_in_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr |-> !r_busy) else $error("team write during clear sweep");
    a_no_rd_in_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd |-> !r_busy) else $error("team read during clear sweep");
    a_clr_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> $past(r_clr_cnt) == (TEAM_BITS+1)'(TEAMS - 1))
        else $error("clear sweep ended early");
    a_rst_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> r_busy) else $error("clear sweep not started by reset");

endmodule

// ----- dv/gftq_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gftq_checker
// Watches both stream channels of the team queue. Every accepted input item
// runs through a linked-list queue predictor with team tail marks and a free
// node stack; the status and element it produces are queued and compared
// field by field with each result item the block hands out.
// ----------------------------------------------------------------------------
module gftq_checker
    import gftq_pkg::*;
#(
    parameter int NODES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,   // element[19:0], team_id[29:20], zero pad
    input  logic [0:0]  i_s_tuser,   // cmd[0]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,   // out_element[19:0], zero pad
    input  logic [1:0]  i_m_tuser,   // status[1:0]
    output int          o_fail_count,
    output int          o_pending
);

    localparam int IDX_BITS = $clog2(NODES);

    typedef struct packed {
        logic [1:0]           status;
        logic [ELEM_BITS-1:0] element;
    } t_queue_result;

    logic [ELEM_BITS-1:0] slot_value [NODES];
    logic [IDX_BITS-1:0]  slot_next  [NODES];
    logic [TEAM_BITS-1:0] slot_team  [NODES];
    logic [IDX_BITS-1:0]  free_list  [NODES];
    logic [IDX_BITS-1:0]  team_last  [TEAMS];
    logic                 team_queued[TEAMS];
    logic [IDX_BITS-1:0]  head_slot;
    logic [IDX_BITS-1:0]  tail_slot;
    int                   free_count;
    int                   fail_total;
    t_queue_result        queue_results[$];

    function automatic t_queue_result queue_apply(logic cmd, logic [ELEM_BITS-1:0] elem,
                                                  logic [TEAM_BITS-1:0] team);
        t_queue_result        res;
        logic [IDX_BITS-1:0]  n;
        logic [IDX_BITS-1:0]  mate;
        logic [TEAM_BITS-1:0] owner;
        logic                 was_empty;
        res = '0;
        if (cmd == CMD_ENQ) begin
            if (free_count == 0) begin
                res.status = ST_FULL;
            end else begin
                was_empty = (free_count == NODES);
                free_count--;
                n = free_list[free_count];
                slot_value[n] = elem;
                slot_team[n]  = team;
                slot_next[n]  = '0;
                if (was_empty) begin
                    head_slot = n;
                    tail_slot = n;
                end else if (team_queued[team]) begin
                    mate = team_last[team];
                    slot_next[n] = slot_next[mate];
                    slot_next[mate] = n;
                    if (tail_slot == mate) tail_slot = n;
                end else begin
                    slot_next[tail_slot] = n;
                    tail_slot = n;
                end
                team_last[team]   = n;
                team_queued[team] = 1'b1;
                res.status = ST_ENQ;
            end
        end else begin
            if (free_count >= NODES) begin
                res.status = ST_EMPTY;
            end else begin
                n = head_slot;
                owner = slot_team[n];
                res.status  = ST_DEQ;
                res.element = slot_value[n];
                if (team_queued[owner] && team_last[owner] == n) team_queued[owner] = 1'b0;
                free_list[free_count] = n;
                free_count++;
                if (free_count == NODES) begin
                    head_slot = '0;
                    tail_slot = '0;
                end else begin
                    head_slot = slot_next[n];
                end
            end
        end
        return res;
    endfunction

    task automatic note_failure(input string what);
        fail_total++;
        if (fail_total <= 10) $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    always @(posedge i_clk) begin
        t_queue_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < NODES; i++) free_list[i] = i[IDX_BITS-1:0];
            for (int i = 0; i < TEAMS; i++) team_queued[i] = 1'b0;
            free_count = NODES;
            head_slot  = '0;
            tail_slot  = '0;
            fail_total = 0;
            queue_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (queue_results.size() == 0) begin
                    note_failure($sformatf("unexpected item status %0d element %0d",
                                           i_m_tuser, i_m_tdata));
                end else begin
                    want = queue_results.pop_front();
                    if (i_m_tuser != want.status || i_m_tdata != {4'b0, want.element}) begin
                        note_failure($sformatf(
                            "expected status %0d element %0d, got status %0d tdata %0d",
                            want.status, want.element, i_m_tuser, i_m_tdata));
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                queue_results.push_back(queue_apply(i_s_tuser[0], i_s_tdata[ELEM_BITS-1:0],
                    i_s_tdata[ELEM_BITS +: TEAM_BITS]));
            end
        end
        o_pending    <= queue_results.size();
        o_fail_count <= fail_total;
    end

endmodule

// ----- dv/grouped_fifo_team_queue_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grouped_fifo_team_queue_tb
// Drives enqueue and dequeue items into the team queue: directed corner
// cases, a random mix of teammates and loners, a fill past full and a drain
// past empty, with bursty input and a stalling output side.
// ----------------------------------------------------------------------------
module grouped_fifo_team_queue_tb;
    import gftq_pkg::*;

    localparam int NODES      = 1024;
    localparam int CYCLE_CAP  = 1000000;
    localparam int RAND_ITEMS = 950;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = CMD_ENQ;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    int          burst_left  = 0;
    int          held        = 0;
    int          stall_mode  = 0;
    int          stall_left  = 0;

    always #1 clk = ~clk;

    grouped_fifo_team_queue #(.NODES(NODES)) u_top (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(s_tready),
        .i_s_tdata (s_tdata),
        .i_s_tuser (s_tuser),
        .o_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata (m_tdata),
        .o_m_tuser (m_tuser)
    );

    gftq_checker #(.NODES(NODES)) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tuser   (m_tuser),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // output side: alternate between free flow, coin-flip and long stalls
    always @(posedge clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(5, 60);
        end
        stall_left--;
        case (stall_mode)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= 1'($urandom_range(0, 1));
            end
            default: begin
                m_tready <= ($urandom_range(0, 7) == 0);
            end
        endcase
    end

    task automatic send_item(input logic cmd, input logic [ELEM_BITS-1:0] elem,
                             input logic [TEAM_BITS-1:0] team);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, team, elem};
        s_tuser  <= cmd;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (cmd == CMD_ENQ) begin
            if (held < NODES) held++;
        end else if (held > 0) begin
            held--;
        end
    endtask

    task automatic enq(input logic [ELEM_BITS-1:0] elem, input logic [TEAM_BITS-1:0] team);
        send_item(CMD_ENQ, elem, team);
    endtask

    task automatic deq();
        send_item(CMD_DEQ, ELEM_BITS'($urandom_range(0, 999999)),
                  TEAM_BITS'($urandom_range(0, 1023)));
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic random_items(input int count);
        int                   deq_pct;
        logic [TEAM_BITS-1:0] team;
        logic [ELEM_BITS-1:0] elem;
        for (int i = 0; i < count; i++) begin
            deq_pct = held == 0 ? 10 : (held > 24 ? 70 : 45);
            if ($urandom_range(0, 99) < 8) deq_pct = 50;
            team = $urandom_range(0, 9) < 8 ? TEAM_BITS'($urandom_range(0, 5))
                                            : TEAM_BITS'($urandom_range(0, 1023));
            case ($urandom_range(0, 19))
                0:       elem = '0;
                1:       elem = ELEM_BITS'(999999);
                default: elem = ELEM_BITS'($urandom_range(0, 999999));
            endcase
            if ($urandom_range(0, 99) < deq_pct) deq();
            else enq(elem, team);
        end
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // empty queue, single element, then teammates joining mid-queue and at the tail
        deq();
        enq('0, '0);
        deq();
        deq();
        enq(ELEM_BITS'(999999), TEAM_BITS'(1023));
        enq(ELEM_BITS'(5), TEAM_BITS'(7));
        enq(ELEM_BITS'(6), TEAM_BITS'(1023));
        enq(ELEM_BITS'(8), TEAM_BITS'(7));
        enq(ELEM_BITS'(9), TEAM_BITS'(0));
        enq(ELEM_BITS'(20'hAAAAA), TEAM_BITS'(10'h155));
        enq(ELEM_BITS'(20'h55555), TEAM_BITS'(10'h2AA));
        enq(ELEM_BITS'(11), TEAM_BITS'(1023));
        repeat (8) deq();
        deq();

        random_items(RAND_ITEMS / 2);
        wait_drain();

        // fill past full, then drain past empty
        while (held < NODES) enq(ELEM_BITS'($urandom_range(0, 999999)),
                                 TEAM_BITS'($urandom_range(0, 15)));
        enq(ELEM_BITS'($urandom_range(0, 999999)), TEAM_BITS'($urandom_range(0, 1023)));
        enq(ELEM_BITS'($urandom_range(0, 999999)), TEAM_BITS'($urandom_range(0, 1023)));
        while (held > 0) deq();
        deq();

        random_items(RAND_ITEMS - RAND_ITEMS / 2);
        wait_drain();
        repeat (100) @(posedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
